// ===== hdl/card_register_buffer_port_macros.svh =====
// ----------------------------------------------------------------------------
// card_register_buffer_port_macros.svh
// Assertion macros used by the register window engine. In synthesis builds the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CARD_REGISTER_BUFFER_PORT_MACROS_SVH
`define CARD_REGISTER_BUFFER_PORT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CRBP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crbp: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CRBP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crbp: next-cycle check failed");

`else

`define CRBP_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CRBP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/crbp_pkg.sv =====
// ----------------------------------------------------------------------------
// crbp_pkg
// Types and constants of the card register window: slot codes, ID values,
// control register indexes and the records passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crbp_pkg;

   // Data buffer geometry.
   localparam int unsigned DATA_DEPTH = 512;
   localparam int unsigned DATA_AW    = 9;

   // Register slot codes on the bus side.
   localparam logic [3:0] SLOT_STATUS = 4'd0;
   localparam logic [3:0] SLOT_PARAM  = 4'd1;
   localparam logic [3:0] SLOT_DATA   = 4'd2;
   localparam logic [3:0] SLOT_ID     = 4'd3;

   // ID byte values; the byte toggles between the two on every ID read.
   localparam logic [7:0] ID_RESET = 8'h96;
   localparam logic [7:0] ID_ALT   = 8'h69;

   // Status bit that marks the card busy.
   localparam int unsigned STATUS_BUSY_BIT = 7;

   // Bit in the data index that selects the upper half.
   localparam int unsigned DATA_HALF_BIT = 8;

   // Control register port.
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic [0:0]  REG_DATA_MODE    = 1'b0;
   localparam logic [0:0]  REG_STATUS_VALUE = 1'b1;

   // Bus function codes.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Control register contents.
   typedef struct packed {
      logic       data_mode;
      logic [7:0] status_value;
   } cfg_type;

   // One bus access.
   typedef struct packed {
      logic [7:0] wdata;
      logic [3:0] reg_sel;
      logic       func;
   } req_type;

   // One access result.
   typedef struct packed {
      logic [7:0] rdata;
      logic       handled;
   } rsp_type;

   // Where the result byte comes from once the result register is loaded.
   typedef enum logic [1:0] {
      SRC_REG   = 2'd0,
      SRC_DATA  = 2'd1,
      SRC_PARAM = 2'd2
   } src_type;

   // Result register contents.
   typedef struct packed {
      src_type    src;
      logic [7:0] rdata;
      logic       handled;
   } res_type;

endpackage

`default_nettype wire

// ===== hdl/crbp_csr.sv =====
// ----------------------------------------------------------------------------
// crbp_csr
// Control registers: data index mode and status byte, on an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module crbp_csr
   import crbp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [0:0] reg_idx;

   // Registers sit on 4-byte boundaries.
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DATA_MODE:    cfg_in.data_mode    = csr_pwdata[0];
            REG_STATUS_VALUE: cfg_in.status_value = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux.
   always_comb begin
      case (reg_idx)
         REG_DATA_MODE:    csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.data_mode};
         REG_STATUS_VALUE: csr_prdata = {{(CSR_DW-8){1'b0}}, cfg_ff.status_value};
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/crbp_ram.sv =====
// ----------------------------------------------------------------------------
// crbp_ram
// Byte buffer with one write and one read port, registered read data, and a
// clearing pass after reset that writes zero to every entry.
// ----------------------------------------------------------------------------
`default_nettype none

module crbp_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data,
   output logic               clear_busy
);

   logic [7:0]    store_ff [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // Clearing pass sweeps one entry per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // The sweep owns the write port while it runs.
   assign mem_we    = clr_busy_ff || wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? 8'h00 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
   end

   // Read data register; it starts at zero to match the cleared buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_data_ff <= '0;
      end else if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

// ===== hdl/crbp_engine.sv =====
// ----------------------------------------------------------------------------
// crbp_engine
// Access engine: input register, slot decode, index stepping, ID toggle and
// result register. The buffer read registers act as the byte latches.
// ----------------------------------------------------------------------------
`default_nettype none

`include "card_register_buffer_port_macros.svh"

module crbp_engine
   import crbp_pkg::*;
#(
   parameter int unsigned PARAM_DEPTH = 32,
   parameter int unsigned PARAM_AW    = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                clear_busy,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp,
   output logic                     data_wr_en,
   output logic      [DATA_AW-1:0]  data_wr_addr,
   output logic                     data_rd_en,
   output logic      [DATA_AW-1:0]  data_rd_addr,
   input  wire logic [7:0]          data_latch,
   output logic                     param_wr_en,
   output logic      [PARAM_AW-1:0] param_wr_addr,
   output logic                     param_rd_en,
   output logic      [PARAM_AW-1:0] param_rd_addr,
   input  wire logic [7:0]          param_latch,
   output logic      [7:0]          wr_byte
);

   req_type             in_ff;
   logic                in_vld_ff;
   logic                in_vld_in;
   res_type             out_ff;
   res_type             out_in;
   logic                out_vld_ff;
   logic                out_vld_in;
   logic [DATA_AW-1:0]  data_pos_ff;
   logic [DATA_AW-1:0]  data_pos_in;
   logic [DATA_AW-1:0]  data_pos_nxt;
   logic [PARAM_AW-1:0] param_pos_ff;
   logic [PARAM_AW-1:0] param_pos_in;
   logic [PARAM_AW-1:0] param_pos_nxt;
   logic [7:0]          ident_ff;
   logic [7:0]          ident_in;
   logic                proc_fire;
   logic                live;
   logic                data_step;
   logic                param_step;
   logic                data_write;
   logic                param_write;

   // Handshake: the input register moves on when the result register is free.
   assign proc_fire = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !clear_busy && (!in_vld_ff || proc_fire);

   // Next data index: linear wrap, or alternate halves.
   always_comb begin
      if (!cfg.data_mode) begin
         data_pos_nxt = data_pos_ff + DATA_AW'(1);
      end else if (data_pos_ff[DATA_HALF_BIT]) begin
         data_pos_nxt = {1'b0, data_pos_ff[DATA_HALF_BIT-1:0] + 8'd1};
      end else begin
         data_pos_nxt = data_pos_ff | DATA_AW'(1 << DATA_HALF_BIT);
      end
   end

   // Next parameter index wraps at the buffer depth.
   assign param_pos_nxt = (param_pos_ff == PARAM_AW'(PARAM_DEPTH - 1)) ? '0
                                                                         : param_pos_ff + PARAM_AW'(1);

   // The fast path serves nothing while the ID is dead or the card is busy.
   assign live = ((ident_ff == ID_RESET) || (ident_ff == ID_ALT))
              && !cfg.status_value[STATUS_BUSY_BIT];

   // Slot decode and result formation.
   always_comb begin
      out_in      = '{src: SRC_REG, rdata: 8'h00, handled: 1'b0};
      ident_in    = ident_ff;
      data_step   = 1'b0;
      param_step  = 1'b0;
      data_write  = 1'b0;
      param_write = 1'b0;
      if (live) begin
         case (in_ff.reg_sel)
            SLOT_STATUS: begin
               if (in_ff.func == FUNC_READ) begin
                  out_in.handled = 1'b1;
                  out_in.rdata   = cfg.status_value;
               end
            end
            SLOT_PARAM: begin
               out_in.handled = 1'b1;
               param_step     = 1'b1;
               if (in_ff.func == FUNC_WRITE) begin
                  param_write = 1'b1;
                  out_in.src  = SRC_PARAM;
               end else begin
                  out_in.rdata = param_latch;
               end
            end
            SLOT_DATA: begin
               out_in.handled = 1'b1;
               data_step      = 1'b1;
               if (in_ff.func == FUNC_WRITE) begin
                  data_write = 1'b1;
                  out_in.src = SRC_DATA;
               end else begin
                  out_in.rdata = data_latch;
               end
            end
            SLOT_ID: begin
               out_in.handled = 1'b1;
               out_in.rdata   = ident_ff;
               if (in_ff.func == FUNC_READ) begin
                  ident_in = ~ident_ff;
               end
            end
            default: begin
               out_in.handled = 1'b0;
            end
         endcase
      end
   end

   // Buffer ports: store at the old index, reload the latch from the new one.
   assign data_wr_en    = proc_fire && data_write;
   assign data_wr_addr  = data_pos_ff;
   assign data_rd_en    = proc_fire && data_step;
   assign data_rd_addr  = data_pos_nxt;
   assign param_wr_en   = proc_fire && param_write;
   assign param_wr_addr = param_pos_ff;
   assign param_rd_en   = proc_fire && param_step;
   assign param_rd_addr = param_pos_nxt;
   assign wr_byte       = in_ff.wdata;

   assign data_pos_in  = (proc_fire && data_step)  ? data_pos_nxt  : data_pos_ff;
   assign param_pos_in = (proc_fire && param_step) ? param_pos_nxt : param_pos_ff;

   // Valid flags of the input and result registers.
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (proc_fire) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (proc_fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         data_pos_ff  <= '0;
         param_pos_ff <= '0;
         ident_ff     <= ID_RESET;
      end else begin
         in_vld_ff    <= in_vld_in;
         out_vld_ff   <= out_vld_in;
         data_pos_ff  <= data_pos_in;
         param_pos_ff <= param_pos_in;
         if (proc_fire) begin
            ident_ff <= ident_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req;
      end
      if (proc_fire) begin
         out_ff <= out_in;
      end
   end

   // A write result takes the freshly reloaded latch from its buffer.
   always_comb begin
      rsp.handled = out_ff.handled;
      case (out_ff.src)
         SRC_DATA:  rsp.rdata = data_latch;
         SRC_PARAM: rsp.rdata = param_latch;
         default:   rsp.rdata = out_ff.rdata;
      endcase
   end

   assign rsp_valid = out_vld_ff;

   // An unhandled result carries zero and reads no latch.
   `CRBP_ASSERT_IMPL(a_unhandled_zero, clock, reset, out_vld_ff && !out_ff.handled, (out_ff.rdata == 8'h00) && (out_ff.src == SRC_REG))

   // The ID byte only ever holds one of its two live values.
   `CRBP_ASSERT_IMPL(a_ident_live, clock, reset, 1'b1, (ident_ff == ID_RESET) || (ident_ff == ID_ALT))

   // An unhandled access leaves all state alone.
   `CRBP_ASSERT_NEXT(a_unhandled_still, clock, reset, proc_fire && !out_in.handled, $stable(data_pos_ff) && $stable(param_pos_ff) && $stable(ident_ff))

   // Half stepping from the lower half keeps the byte offset.
   `CRBP_ASSERT_NEXT(a_half_step, clock, reset, proc_fire && data_step && cfg.data_mode && !data_pos_ff[DATA_HALF_BIT], data_pos_ff[DATA_HALF_BIT] && (data_pos_ff[DATA_HALF_BIT-1:0] == $past(data_pos_ff[DATA_HALF_BIT-1:0])))

endmodule

`default_nettype wire

// ===== hdl/card_register_buffer_port.sv =====
// ----------------------------------------------------------------------------
// card_register_buffer_port
// Fast path of a peripheral card's four-slot register window with a data
// buffer, a parameter buffer and a toggling ID byte.
// ----------------------------------------------------------------------------
// After reset both buffers are swept to zero, one entry per cycle;
// req_tready stays low until the sweep is done, while control register writes
// are accepted throughout. From then on one access is accepted every cycle as
// long as the result channel takes each result. Each access passes through
// the input register and then the result register, whose byte on a buffer
// write comes from that buffer's read port.
// Each buffer has one write and one read port, so a write stores its byte and
// reloads the latch from the advanced index in the same cycle. A result that
// is not taken holds the input side after the input register fills.
// ----------------------------------------------------------------------------
`default_nettype none

module card_register_buffer_port
   import crbp_pkg::*;
#(
   parameter int unsigned PARAM_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Access channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] wdata
   input  wire logic [4:0]        req_tuser,   // [0] func, [4:1] reg_sel
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [7:0]        rsp_tdata,   // [7:0] rdata
   output logic      [0:0]        rsp_tuser,   // [0] handled
   // Control register port.
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int unsigned PARAM_AW = $clog2(PARAM_DEPTH);

   cfg_type             cfg;
   req_type             req;
   rsp_type             rsp;
   logic                data_busy;
   logic                param_busy;
   logic                data_wr_en;
   logic [DATA_AW-1:0]  data_wr_addr;
   logic                data_rd_en;
   logic [DATA_AW-1:0]  data_rd_addr;
   logic [7:0]          data_latch;
   logic                param_wr_en;
   logic [PARAM_AW-1:0] param_wr_addr;
   logic                param_rd_en;
   logic [PARAM_AW-1:0] param_rd_addr;
   logic [7:0]          param_latch;
   logic [7:0]          wr_byte;

   // Unpack the access and pack the result.
   assign req.func    = req_tuser[0];
   assign req.reg_sel = req_tuser[4:1];
   assign req.wdata   = req_tdata;
   assign rsp_tdata   = rsp.rdata;
   assign rsp_tuser   = rsp.handled;

   crbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crbp_ram #(
      .DEPTH (DATA_DEPTH),
      .AW    (DATA_AW)
   ) u_data_ram (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (data_wr_en),
      .wr_addr    (data_wr_addr),
      .wr_data    (wr_byte),
      .rd_en      (data_rd_en),
      .rd_addr    (data_rd_addr),
      .rd_data    (data_latch),
      .clear_busy (data_busy)
   );

   crbp_ram #(
      .DEPTH (PARAM_DEPTH),
      .AW    (PARAM_AW)
   ) u_param_ram (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (param_wr_en),
      .wr_addr    (param_wr_addr),
      .wr_data    (wr_byte),
      .rd_en      (param_rd_en),
      .rd_addr    (param_rd_addr),
      .rd_data    (param_latch),
      .clear_busy (param_busy)
   );

   crbp_engine #(
      .PARAM_DEPTH (PARAM_DEPTH),
      .PARAM_AW    (PARAM_AW)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .clear_busy    (data_busy || param_busy),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req           (req),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp),
      .data_wr_en    (data_wr_en),
      .data_wr_addr  (data_wr_addr),
      .data_rd_en    (data_rd_en),
      .data_rd_addr  (data_rd_addr),
      .data_latch    (data_latch),
      .param_wr_en   (param_wr_en),
      .param_wr_addr (param_wr_addr),
      .param_rd_en   (param_rd_en),
      .param_rd_addr (param_rd_addr),
      .param_latch   (param_latch),
      .wr_byte       (wr_byte)
   );

endmodule

`default_nettype wire
